### rtl/imac_pkg.sv
// Shared types and constants for the multiply-accumulate-long execute unit.
package imac_pkg;

  localparam int WORD_W    = 32;
  localparam int ACC_W     = 2 * WORD_W;
  localparam int OPCODE_W  = 3;
  localparam int FW_W      = 2;
  localparam int DIGIT_W   = 8;
  localparam int NUM_CELLS = WORD_W / DIGIT_W;

  localparam int CARRY_POS    = 2;
  localparam int OVERFLOW_POS = 10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_MUL   = 3'd0,
    OP_MLA   = 3'd1,
    OP_UMULL = 3'd2,
    OP_UMLAL = 3'd3,
    OP_SMULL = 3'd4,
    OP_SMLAL = 3'd5
  } opcode_t;

  localparam logic [FW_W-1:0] FW_NONE = 2'd0;
  localparam logic [FW_W-1:0] FW_ZNC  = 2'd1;
  localparam logic [FW_W-1:0] FW_ALL  = 2'd2;

  typedef struct packed {
    logic legal;
    logic long_form;
    logic set_flags;
  } ctrl_t;

  typedef struct packed {
    ctrl_t              ctrl;
    logic [ACC_W-1:0]   mcand;
    logic [WORD_W-1:0]  mplier;
    logic [ACC_W-1:0]   acc;
  } stage_t;

endpackage

### rtl/imac_in_if.sv
// Input channel: operation, flag request, factors and addend.
interface imac_in_if;
  logic                           valid;
  logic                           ready;
  logic [imac_pkg::OPCODE_W-1:0]  opcode;
  logic                           set_flags;
  logic [imac_pkg::WORD_W-1:0]    factor_m;
  logic [imac_pkg::WORD_W-1:0]    factor_s;
  logic [imac_pkg::WORD_W-1:0]    addend_lo;
  logic [imac_pkg::WORD_W-1:0]    addend_hi;

  modport source (output valid, opcode, set_flags, factor_m, factor_s, addend_lo, addend_hi,
                  input ready);
  modport sink   (input valid, opcode, set_flags, factor_m, factor_s, addend_lo, addend_hi,
                  output ready);
endinterface

### rtl/imac_out_if.sv
// Result channel: result words and condition flags.
interface imac_out_if;
  logic                         valid;
  logic                         ready;
  logic [imac_pkg::WORD_W-1:0]  result_lo;
  logic [imac_pkg::WORD_W-1:0]  result_hi;
  logic                         flag_zero;
  logic                         flag_negative;
  logic                         flag_carry;
  logic                         flag_overflow;
  logic [imac_pkg::FW_W-1:0]    flags_written;

  modport source (output valid, result_lo, result_hi, flag_zero, flag_negative, flag_carry,
                  flag_overflow, flags_written, input ready);
  modport sink   (input valid, result_lo, result_hi, flag_zero, flag_negative, flag_carry,
                  flag_overflow, flags_written, output ready);
endinterface

### rtl/imac_cell.sv
// Multiplier cell: adds one multiplier digit's partial product, passes operands on.
module imac_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  output logic             ready_o,
  input  imac_pkg::stage_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output imac_pkg::stage_t data_o
);

  logic                           valid_r, valid_nxt;
  imac_pkg::stage_t               data_r, data_nxt;
  logic [imac_pkg::DIGIT_W-1:0]   digit;
  logic [imac_pkg::ACC_W-1:0]     partial;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    digit           = data_i.mplier[imac_pkg::DIGIT_W-1:0];
    partial         = data_i.mcand * {{(imac_pkg::ACC_W-imac_pkg::DIGIT_W){1'b0}}, digit};
    data_nxt.ctrl   = data_i.ctrl;
    data_nxt.mcand  = data_i.mcand << imac_pkg::DIGIT_W;
    data_nxt.mplier = data_i.mplier >> imac_pkg::DIGIT_W;
    data_nxt.acc    = data_i.acc + partial;
    valid_nxt       = ready_o ? valid_i : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### rtl/integer_multiply_accumulate_long.sv
// Top level of the multiply-accumulate-long execute unit.
//
//   channel | dir | handshake     | beat
//   in_ch   | in  | valid / ready | opcode, set_flags, factor_m, factor_s, addend_lo/hi
//   out_ch  | out | valid / ready | result_lo/hi, flag_zero/negative/carry/overflow,
//           |     |               | flags_written
//
// One beat per cycle while out_ch is not stalled; stages are a decode stage, four 8-bit multiplier
// cells and the flag/output register.
// Each stage holds its beat while the next is full and stalled; empty stages fill.
// Reset (rst_n low, synchronous) empties every stage; no other state.
module integer_multiply_accumulate_long (
  input  logic        clk,
  input  logic        rst_n,
  imac_in_if.sink     in_ch,
  imac_out_if.source  out_ch
);

  localparam int W = imac_pkg::WORD_W;

  logic             valid_c [imac_pkg::NUM_CELLS+1];
  logic             ready_c [imac_pkg::NUM_CELLS+1];
  imac_pkg::stage_t data_c  [imac_pkg::NUM_CELLS+1];

  // entry stage
  logic             entry_valid_r, entry_valid_nxt;
  imac_pkg::stage_t entry_r, entry_nxt;
  logic             entry_ready;
  logic             acc_en, is_signed;
  logic [W-1:0]     alo_eff, ahi_eff, corr_m, corr_s;

  always_comb begin
    entry_nxt.ctrl.legal     = 1'b1;
    entry_nxt.ctrl.long_form = 1'b1;
    entry_nxt.ctrl.set_flags = in_ch.set_flags;
    acc_en                   = 1'b0;
    is_signed                = 1'b0;
    unique case (imac_pkg::opcode_t'(in_ch.opcode))
      imac_pkg::OP_MUL: begin
        entry_nxt.ctrl.long_form = 1'b0;
      end
      imac_pkg::OP_MLA: begin
        entry_nxt.ctrl.long_form = 1'b0;
        acc_en                   = 1'b1;
      end
      imac_pkg::OP_UMULL: begin
      end
      imac_pkg::OP_UMLAL: begin
        acc_en = 1'b1;
      end
      imac_pkg::OP_SMULL: begin
        is_signed = 1'b1;
      end
      imac_pkg::OP_SMLAL: begin
        is_signed = 1'b1;
        acc_en    = 1'b1;
      end
      default: begin
        entry_nxt.ctrl.legal = 1'b0;
      end
    endcase
    alo_eff = acc_en ? in_ch.addend_lo : '0;
    ahi_eff = (acc_en && entry_nxt.ctrl.long_form) ? in_ch.addend_hi : '0;
    // two's complement fixup of the unsigned product, folded into the start value
    corr_m  = (is_signed && in_ch.factor_m[W-1]) ? in_ch.factor_s : '0;
    corr_s  = (is_signed && in_ch.factor_s[W-1]) ? in_ch.factor_m : '0;
    entry_nxt.mcand  = {{W{1'b0}}, in_ch.factor_m};
    entry_nxt.mplier = in_ch.factor_s;
    entry_nxt.acc    = {ahi_eff - corr_m - corr_s, alo_eff};
    entry_valid_nxt  = entry_ready ? in_ch.valid : entry_valid_r;
  end

  assign entry_ready = !entry_valid_r || ready_c[0];
  assign in_ch.ready = entry_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else begin
      entry_valid_r <= entry_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_ready && in_ch.valid) begin
      entry_r <= entry_nxt;
    end
  end

  assign valid_c[0] = entry_valid_r;
  assign data_c[0]  = entry_r;

  for (genvar i = 0; i < imac_pkg::NUM_CELLS; i++) begin : g_cell
    imac_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_c[i]),
      .ready_o (ready_c[i]),
      .data_i  (data_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (ready_c[i+1]),
      .data_o  (data_c[i+1])
    );
  end

  // output stage
  logic                       out_valid_r, out_valid_nxt;
  logic [W-1:0]               lo_r, lo_nxt, hi_r, hi_nxt;
  logic                       z_r, z_nxt, n_r, n_nxt, c_r, c_nxt, v_r, v_nxt;
  logic [imac_pkg::FW_W-1:0]  fw_r, fw_nxt;
  imac_pkg::stage_t           last;

  assign last                             = data_c[imac_pkg::NUM_CELLS];
  assign ready_c[imac_pkg::NUM_CELLS]     = !out_valid_r || out_ch.ready;

  always_comb begin
    lo_nxt = '0;
    hi_nxt = '0;
    z_nxt  = 1'b0;
    n_nxt  = 1'b0;
    c_nxt  = 1'b0;
    v_nxt  = 1'b0;
    fw_nxt = imac_pkg::FW_NONE;
    priority if (!last.ctrl.legal) begin
    end else if (last.ctrl.long_form) begin
      lo_nxt = last.acc[W-1:0];
      hi_nxt = last.acc[imac_pkg::ACC_W-1:W];
      if (last.ctrl.set_flags) begin
        z_nxt  = (last.acc == '0);
        n_nxt  = last.acc[imac_pkg::ACC_W-1];
        c_nxt  = last.acc[imac_pkg::CARRY_POS];
        v_nxt  = last.acc[imac_pkg::OVERFLOW_POS];
        fw_nxt = imac_pkg::FW_ALL;
      end
    end else begin
      lo_nxt = last.acc[W-1:0];
      if (last.ctrl.set_flags) begin
        z_nxt  = (last.acc[W-1:0] == '0);
        n_nxt  = last.acc[W-1];
        c_nxt  = last.acc[imac_pkg::CARRY_POS];
        fw_nxt = imac_pkg::FW_ZNC;
      end
    end
    out_valid_nxt = ready_c[imac_pkg::NUM_CELLS] ? valid_c[imac_pkg::NUM_CELLS] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c[imac_pkg::NUM_CELLS] && valid_c[imac_pkg::NUM_CELLS]) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      z_r  <= z_nxt;
      n_r  <= n_nxt;
      c_r  <= c_nxt;
      v_r  <= v_nxt;
      fw_r <= fw_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_lo     = lo_r;
  assign out_ch.result_hi     = hi_r;
  assign out_ch.flag_zero     = z_r;
  assign out_ch.flag_negative = n_r;
  assign out_ch.flag_carry    = c_r;
  assign out_ch.flag_overflow = v_r;
  assign out_ch.flags_written = fw_r;

endmodule

### rtl/imac_chk.sv
// Port-level checks for the multiply-accumulate-long unit, bound to the top level.
module imac_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [imac_pkg::WORD_W-1:0] result_lo,
  input logic [imac_pkg::WORD_W-1:0] result_hi,
  input logic                       flag_zero,
  input logic                       flag_negative,
  input logic                       flag_carry,
  input logic                       flag_overflow,
  input logic [imac_pkg::FW_W-1:0]   flags_written
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_lo) && $stable(result_hi))
    else $error("result beat dropped or changed while stalled");

  a_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && flags_written == imac_pkg::FW_NONE
      |-> !flag_zero && !flag_negative && !flag_carry && !flag_overflow)
    else $error("flag set without flag write");

  a_short_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && flags_written == imac_pkg::FW_ZNC
      |-> result_hi == '0 && !flag_overflow && flag_zero == (result_lo == '0)
          && flag_negative == result_lo[imac_pkg::WORD_W-1])
    else $error("short form flags inconsistent");

  a_long_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && flags_written == imac_pkg::FW_ALL
      |-> flag_zero == (result_lo == '0 && result_hi == '0)
          && flag_negative == result_hi[imac_pkg::WORD_W-1]
          && flag_carry == result_lo[imac_pkg::CARRY_POS]
          && flag_overflow == result_lo[imac_pkg::OVERFLOW_POS])
    else $error("long form flags inconsistent");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind integer_multiply_accumulate_long imac_chk u_imac_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .result_lo     (out_ch.result_lo),
  .result_hi     (out_ch.result_hi),
  .flag_zero     (out_ch.flag_zero),
  .flag_negative (out_ch.flag_negative),
  .flag_carry    (out_ch.flag_carry),
  .flag_overflow (out_ch.flag_overflow),
  .flags_written (out_ch.flags_written)
);

### tb/sv/tb_integer_multiply_accumulate_long.sv
// Testbench for the multiply-accumulate-long unit: directed and random beats, scoreboard checked.
module tb_integer_multiply_accumulate_long;
  import imac_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD_B = 3'd7;
  localparam int QUIET_LIMIT  = 1000;
  localparam int FLUSH_CYCLES = 24;
  localparam int SEG_ITEMS    = 150;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                set_flags;
    logic [WORD_W-1:0]   factor_m;
    logic [WORD_W-1:0]   factor_s;
    logic [WORD_W-1:0]   addend_lo;
    logic [WORD_W-1:0]   addend_hi;
  } mac_op_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_lo;
    logic [WORD_W-1:0] result_hi;
    logic              flag_zero;
    logic              flag_negative;
    logic              flag_carry;
    logic              flag_overflow;
    logic [FW_W-1:0]   flags_written;
  } mac_res_t;

  class mac_scoreboard;
    mac_res_t expected_q[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function mac_res_t compute_mac(mac_op_t b);
      logic [ACC_W-1:0]  wide_m;
      logic [ACC_W-1:0]  wide_s;
      logic [ACC_W-1:0]  prod;
      logic [WORD_W-1:0] short_r;
      logic              signed_form;
      mac_res_t          r;
      r = '0;
      case (b.opcode)
        OP_MUL, OP_MLA: begin
          short_r = b.factor_m * b.factor_s;
          if (b.opcode == OP_MLA) short_r = short_r + b.addend_lo;
          r.result_lo = short_r;
          if (b.set_flags) begin
            r.flag_zero     = (short_r == '0);
            r.flag_negative = short_r[WORD_W-1];
            r.flag_carry    = short_r[CARRY_POS];
            r.flags_written = FW_ZNC;
          end
        end
        OP_UMULL, OP_UMLAL, OP_SMULL, OP_SMLAL: begin
          signed_form = (b.opcode == OP_SMULL) || (b.opcode == OP_SMLAL);
          wide_m = {{WORD_W{signed_form & b.factor_m[WORD_W-1]}}, b.factor_m};
          wide_s = {{WORD_W{signed_form & b.factor_s[WORD_W-1]}}, b.factor_s};
          prod = wide_m * wide_s;
          if ((b.opcode == OP_UMLAL) || (b.opcode == OP_SMLAL))
            prod = prod + {b.addend_hi, b.addend_lo};
          r.result_lo = prod[WORD_W-1:0];
          r.result_hi = prod[ACC_W-1:WORD_W];
          if (b.set_flags) begin
            r.flag_zero     = (prod == '0);
            r.flag_negative = prod[ACC_W-1];
            r.flag_carry    = prod[CARRY_POS];
            r.flag_overflow = prod[OVERFLOW_POS];
            r.flags_written = FW_ALL;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(mac_op_t b);
      expected_q = {expected_q, compute_mac(b)};
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(mac_res_t a);
      mac_res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual lo %h hi %h",
                 $time, a.result_lo, a.result_hi);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("result_lo", e.result_lo, a.result_lo);
      compare_field("result_hi", e.result_hi, a.result_hi);
      compare_field("flag_zero", WORD_W'(e.flag_zero), WORD_W'(a.flag_zero));
      compare_field("flag_negative", WORD_W'(e.flag_negative), WORD_W'(a.flag_negative));
      compare_field("flag_carry", WORD_W'(e.flag_carry), WORD_W'(a.flag_carry));
      compare_field("flag_overflow", WORD_W'(e.flag_overflow), WORD_W'(a.flag_overflow));
      compare_field("flags_written", WORD_W'(e.flags_written), WORD_W'(a.flags_written));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  imac_in_if  in_ch();
  imac_out_if out_ch();

  mac_scoreboard board;
  int pace = 1;
  int sink_hold = 0;
  int quiet = 0;

  integer_multiply_accumulate_long DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic mac_op_t beat(logic [OPCODE_W-1:0] op, logic sf, logic [WORD_W-1:0] m,
                                   logic [WORD_W-1:0] s, logic [WORD_W-1:0] alo,
                                   logic [WORD_W-1:0] ahi);
    mac_op_t b;
    b.opcode    = op;
    b.set_flags = sf;
    b.factor_m  = m;
    b.factor_s  = s;
    b.addend_lo = alo;
    b.addend_hi = ahi;
    return b;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return WORD_W'($urandom_range(0, 15));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic send_item(mac_op_t b);
    int gap;
    gap = 0;
    if (pace != 0 && $urandom_range(0, (pace == 2) ? 2 : 6) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= b.opcode;
    in_ch.set_flags <= b.set_flags;
    in_ch.factor_m  <= b.factor_m;
    in_ch.factor_s  <= b.factor_s;
    in_ch.addend_lo <= b.addend_lo;
    in_ch.addend_hi <= b.addend_hi;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(b);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // result side: check accepted beats, random stall bursts
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result('{out_ch.result_lo, out_ch.result_hi, out_ch.flag_zero,
                           out_ch.flag_negative, out_ch.flag_carry, out_ch.flag_overflow,
                           out_ch.flags_written});
    if (sink_hold > 0) begin
      sink_hold    <= sink_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (pace != 0 && $urandom_range(0, (pace == 2) ? 2 : 6) == 0) begin
      sink_hold    <= $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("integer_multiply_accumulate_long verification failed");
    $finish;
  end

  initial begin
    mac_op_t b;
    int      seg_pace[5];
    board = new();
    seg_pace = '{1, 2, 0, 1, 0};
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.set_flags = 1'b0;
    in_ch.factor_m = '0;
    in_ch.factor_s = '0;
    in_ch.addend_lo = '0;
    in_ch.addend_hi = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(beat(OP_MUL,    1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'h0,         32'h0));
    send_item(beat(OP_MUL,    1'b1, 32'h0,         32'h1234_5678, 32'hffff_ffff, 32'hffff_ffff));
    send_item(beat(OP_MUL,    1'b0, 32'hffff_ffff, 32'h2,         32'h5,         32'h0));
    send_item(beat(OP_MLA,    1'b1, 32'hffff_ffff, 32'h1,         32'h1,         32'hffff_ffff));
    send_item(beat(OP_MLA,    1'b1, 32'h8000_0000, 32'h1,         32'h4,         32'h0));
    send_item(beat(OP_MLA,    1'b0, 32'h8000_0000, 32'h1,         32'h4,         32'hffff_ffff));
    send_item(beat(OP_UMULL,  1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send_item(beat(OP_UMULL,  1'b1, 32'h404,       32'h1,         32'h0,         32'h0));
    send_item(beat(OP_UMULL,  1'b1, 32'h0,         32'hffff_ffff, 32'h0,         32'h0));
    send_item(beat(OP_UMLAL,  1'b1, 32'h1,         32'h1,         32'hffff_ffff, 32'hffff_ffff));
    send_item(beat(OP_UMLAL,  1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send_item(beat(OP_UMLAL,  1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h404,       32'h8000_0000));
    send_item(beat(OP_SMULL,  1'b1, 32'h8000_0000, 32'h8000_0000, 32'h0,         32'h0));
    send_item(beat(OP_SMULL,  1'b1, 32'hffff_ffff, 32'h1,         32'hffff_ffff, 32'h0));
    send_item(beat(OP_SMULL,  1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h0,         32'hffff_ffff));
    send_item(beat(OP_SMULL,  1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'h0,         32'h0));
    send_item(beat(OP_SMLAL,  1'b1, 32'hffff_ffff, 32'h1,         32'h1,         32'h0));
    send_item(beat(OP_SMLAL,  1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff));
    send_item(beat(OP_SMLAL,  1'b0, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff));
    send_item(beat(OP_RSVD_A, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send_item(beat(OP_RSVD_B, 1'b1, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 32'hf0f0_f0f0));
    send_item(beat(OP_RSVD_B, 1'b0, 32'h0,         32'h0,         32'h0,         32'h0));

    for (int seg = 0; seg < 5; seg++) begin
      pace <= seg_pace[seg];
      repeat (SEG_ITEMS) begin
        if ($urandom_range(0, 15) == 0)
          b.opcode = ($urandom_range(0, 1) == 0) ? OP_RSVD_A : OP_RSVD_B;
        else
          b.opcode = OPCODE_W'($urandom_range(OP_MUL, OP_SMLAL));
        b.set_flags = $urandom_range(0, 3) != 0;
        b.factor_m  = pick_word();
        b.factor_s  = pick_word();
        b.addend_lo = pick_word();
        b.addend_hi = pick_word();
        send_item(b);
      end
      if (seg == 1) drain_results();
    end

    drain_results();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("integer_multiply_accumulate_long verification clean");
    end else begin
      $display("integer_multiply_accumulate_long verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/imac_pkg.sv
rtl/imac_in_if.sv
rtl/imac_out_if.sv
rtl/imac_cell.sv
rtl/integer_multiply_accumulate_long.sv
rtl/imac_chk.sv
tb/sv/tb_integer_multiply_accumulate_long.sv
